FILE: sv/bqeq_pkg.sv
// ----------------------------------------------------------------------------
// Biquad cascade equalizer package
// Widths, fixed-point formats, operation codes and the saturation helpers
// shared by the equalizer datapath.
// ----------------------------------------------------------------------------
package bqeq_pkg;

   // Structure of the cascade.
   localparam int NUM_BANDS    = 10;
   localparam int NUM_CHANNELS = 2;
   localparam int NUM_COEFFS   = 5;

   // Fixed-point formats. Coefficients carry COEFF_WIDTH-6 fraction bits,
   // the signal and the delay states carry STATE_FRAC fraction bits.
   localparam int COEFF_WIDTH = 32;
   localparam int STATE_WIDTH = 40;
   localparam int STATE_FRAC  = 30;
   localparam int COEFF_FRAC  = COEFF_WIDTH - 6;

   // Port field widths.
   localparam int OP_W        = 2;
   localparam int SAMPLE_W    = 16;
   localparam int SAMPLE_FRAC = 15;
   localparam int BAND_W      = 4;
   localparam int CSEL_W      = 3;
   localparam int CVAL_W      = 32;
   localparam int EN_W        = 10;

   // Input samples are Q1.15 and move up to the internal fraction position.
   localparam int IN_SHIFT = STATE_FRAC - SAMPLE_FRAC;

   // The state operand of a product is split into two halves so that the
   // multiplier stays about 32 by 21 bits. The low half is unsigned.
   localparam int LO_W   = STATE_WIDTH / 2;
   localparam int HI_W   = STATE_WIDTH - LO_W;
   localparam int MOP_W  = HI_W + 1;
   localparam int PP_W   = COEFF_WIDTH + MOP_W;
   localparam int PROD_W = COEFF_WIDTH + STATE_WIDTH;
   localparam int SHR_W  = PROD_W - COEFF_FRAC;
   localparam int SUM_W  = STATE_WIDTH + 2;
   localparam int MAG_W  = STATE_FRAC + 1;
   localparam int SCL_W  = MAG_W + SAMPLE_FRAC;

   // Memory geometry: coefficients at {band, coeff_sel}, delay states at
   // {band, channel, state index}.
   localparam int COEF_DEPTH = NUM_BANDS << CSEL_W;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int DLY_DEPTH  = NUM_BANDS << 2;
   localparam int DLY_AW     = $clog2(DLY_DEPTH);

   localparam int CIN_EXT_W = (COEFF_WIDTH > CVAL_W) ? COEFF_WIDTH : CVAL_W;

   typedef enum logic [OP_W-1:0] {
      OP_FILTER = 2'd0,
      OP_COEFF  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   localparam logic [CSEL_W-1:0] CSEL_B0 = 3'd0;
   localparam logic [CSEL_W-1:0] CSEL_A1 = 3'd3;

   localparam logic [EN_W-1:0] EN_MASK = EN_W'((64'd1 << NUM_BANDS) - 64'd1);

   localparam logic signed [COEFF_WIDTH-1:0] COEFF_ONE =
      {5'b0, 1'b1, {COEFF_FRAC{1'b0}}};
   localparam logic signed [COEFF_WIDTH-1:0] COEFF_MAX =
      {1'b0, {(COEFF_WIDTH-1){1'b1}}};
   localparam logic signed [COEFF_WIDTH-1:0] COEFF_MIN =
      {1'b1, {(COEFF_WIDTH-1){1'b0}}};
   localparam logic signed [STATE_WIDTH-1:0] STATE_MAX =
      {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [STATE_WIDTH-1:0] STATE_MIN =
      {1'b1, {(STATE_WIDTH-1){1'b0}}};

   localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {STATE_FRAC{1'b0}}};

   // Saturate a written coefficient to the coefficient width.
   function automatic logic signed [COEFF_WIDTH-1:0] sat_coeff(
      input logic signed [CVAL_W-1:0] v);
      logic signed [CIN_EXT_W-1:0] w;
      w = CIN_EXT_W'(v);
      if (w > CIN_EXT_W'(COEFF_MAX)) begin
         return COEFF_MAX;
      end else if (w < CIN_EXT_W'(COEFF_MIN)) begin
         return COEFF_MIN;
      end
      return COEFF_WIDTH'(w);
   endfunction

   // Drop the coefficient fraction bits (floor) and saturate to state width.
   function automatic logic signed [STATE_WIDTH-1:0] sat_prod(
      input logic signed [PROD_W-1:0] p);
      logic signed [SHR_W-1:0] q;
      q = SHR_W'(p >>> COEFF_FRAC);
      if (q > SHR_W'(STATE_MAX)) begin
         return STATE_MAX;
      end else if (q < SHR_W'(STATE_MIN)) begin
         return STATE_MIN;
      end
      return STATE_WIDTH'(q);
   endfunction

   // Saturate an accumulated sum to state width.
   function automatic logic signed [STATE_WIDTH-1:0] sat_sum(
      input logic signed [SUM_W-1:0] s);
      if (s > SUM_W'(STATE_MAX)) begin
         return STATE_MAX;
      end else if (s < SUM_W'(STATE_MIN)) begin
         return STATE_MIN;
      end
      return STATE_WIDTH'(s);
   endfunction

endpackage

FILE: sv/bqeq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bqeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/biquad_cascade_equalizer.sv
// ----------------------------------------------------------------------------
// Biquad cascade equalizer
// Ten-band series cascade of transposed direct form II biquads on 16-bit
// audio with one set of delay states per channel.
// ----------------------------------------------------------------------------
// A filter word runs through the enabled bands in order on one shared
// multiplier: each of the five products of a band takes two multiplier
// passes (low and high half of the signal), and a disabled band is passed
// over at its first step. req_stall is high until the result of a filter
// word has been loaded into an output register; the next word is taken
// while the result waits there. Coefficient writes and clears do not stall
// the input. Coefficients and delay states live in RAMs whose entries carry
// valid bits, so reset and clear need no sweep.
module biquad_cascade_equalizer import bqeq_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [EN_W-1:0]            csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_op,
   input  logic                       req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic [BAND_W-1:0]          req_band_sel,
   input  logic [CSEL_W-1:0]          req_coeff_sel,
   input  logic signed [CVAL_W-1:0]   req_coeff_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_channel_out,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAND,
      ST_FIN_MAG,
      ST_FIN_SCALE,
      ST_SEND
   } state_type;

   // Schedule of one enabled band. Coefficient k is read at step 2k, its
   // low and high products at 2k+1 and 2k+2, and the full product is ready
   // to be summed at step 2k+4.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_FIRST     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RD_S1     = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SUM_Y     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_RD_S2     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_LOAD_Y    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SUM_A1    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MUL_Y     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_LAST_RD   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_SUM_A2    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_SUB_A1    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_LAST_MUL  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_WR_S1     = 4'd11;
   localparam logic [STEP_W-1:0] STEP_LAST_ADD  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_SUB_A2    = 4'd12;
   localparam logic [STEP_W-1:0] STEP_WR_S2     = 4'd13;
   localparam logic [STEP_W-1:0] STEP_FIRST_ACC = 4'd2;

   localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(NUM_BANDS - 1);
   localparam int EN_EXT_W = 1 << BAND_W;

   // Control registers.
   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [BAND_W-1:0]         band_ff, band_in;
   logic                      ch_ff, ch_in;
   logic [EN_W-1:0]           en_ff, en_in;
   logic [COEF_DEPTH-1:0]     coef_vld_ff, coef_vld_in;
   logic [DLY_DEPTH-1:0]      dly_vld_ff, dly_vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_channel_ff, rsp_channel_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   // Datapath registers.
   logic signed [STATE_WIDTH-1:0] x_ff, x_in;
   logic signed [STATE_WIDTH-1:0] y_ff, y_in;
   logic signed [PP_W-1:0]        pp_ff, pp_in;
   logic signed [PROD_W-1:0]      acc_ff, acc_in;
   logic signed [SUM_W-1:0]       ya_ff, ya_in;
   logic signed [SUM_W-1:0]       a1_ff, a1_in;
   logic signed [SUM_W-1:0]       a2_ff, a2_in;
   logic                          cuse_ff, cuse_in;
   logic signed [COEFF_WIDTH-1:0] cdef_ff, cdef_in;
   logic                          dvld_ff, dvld_in;
   logic [MAG_W-1:0]              mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic signed [SAMPLE_W-1:0]    res_ff, res_in;

   // Combinational signals.
   logic                          accept;
   logic                          ch_ok;
   logic                          in_band;
   logic [EN_EXT_W-1:0]           en_ext;
   logic                          band_en;
   logic                          band_done;
   logic                          rsp_load;
   logic                          coef_we;
   logic [COEF_AW-1:0]            coef_waddr;
   logic signed [COEFF_WIDTH-1:0] coef_wdata;
   logic                          coef_re;
   logic [CSEL_W-1:0]             coef_k;
   logic [COEF_AW-1:0]            coef_raddr;
   logic [COEFF_WIDTH-1:0]        coef_rd_data;
   logic signed [COEFF_WIDTH-1:0] coef_eff;
   logic                          dly_we;
   logic                          dly_wk;
   logic [DLY_AW-1:0]             dly_waddr;
   logic signed [STATE_WIDTH-1:0] dly_wdata;
   logic                          dly_re;
   logic                          dly_rk;
   logic [DLY_AW-1:0]             dly_raddr;
   logic [STATE_WIDTH-1:0]        dly_rd_data;
   logic signed [STATE_WIDTH-1:0] s_eff;
   logic signed [STATE_WIDTH-1:0] mul_v;
   logic signed [MOP_W-1:0]       mop;
   logic signed [STATE_WIDTH-1:0] p_val;
   logic signed [SUM_W-1:0]       p_ext;
   logic signed [SUM_W-1:0]       s_ext;
   logic [STATE_WIDTH:0]          absx;
   logic [SCL_W-1:0]              scaled;
   logic [SAMPLE_W-1:0]           mag_out;

   assign accept    = req_valid && !req_stall;
   assign ch_ok     = (NUM_CHANNELS > 1) || (req_channel == 1'b0);
   assign in_band   = (state_ff == ST_BAND);
   assign en_ext    = EN_EXT_W'(en_ff);
   assign band_en   = en_ext[band_ff];
   assign band_done = in_band && (((step_ff == STEP_FIRST) && !band_en)
                                  || (step_ff == STEP_WR_S2));
   assign rsp_load  = (state_ff == ST_SEND) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_sample_out  = rsp_sample_ff;

   // ------------------------------------------------------------------------
   // Coefficient memory
   // ------------------------------------------------------------------------
   assign coef_we    = accept && (req_op == OP_COEFF)
                       && ({1'b0, req_band_sel} < (BAND_W + 1)'(NUM_BANDS))
                       && (req_coeff_sel < CSEL_W'(NUM_COEFFS));
   assign coef_waddr = COEF_AW'({req_band_sel, req_coeff_sel});
   assign coef_wdata = sat_coeff(req_coeff_value);

   assign coef_re    = in_band && band_en && !step_ff[0] && (step_ff <= STEP_LAST_RD);
   assign coef_k     = CSEL_W'(step_ff >> 1);
   assign coef_raddr = COEF_AW'({band_ff, coef_k});

   bqeq_ram #(
      .WIDTH (COEFF_WIDTH),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_en   (coef_re),
      .rd_addr (coef_raddr),
      .rd_data (coef_rd_data)
   );

   // An entry never written reads as the identity filter.
   assign coef_eff = cuse_ff ? coef_rd_data : cdef_ff;

   // ------------------------------------------------------------------------
   // Delay state memory
   // ------------------------------------------------------------------------
   assign dly_re    = in_band && ((step_ff == STEP_RD_S1) || (step_ff == STEP_RD_S2));
   assign dly_rk    = (step_ff == STEP_RD_S2);
   assign dly_raddr = DLY_AW'({band_ff, ch_ff, dly_rk});

   assign dly_we    = in_band && ((step_ff == STEP_WR_S1) || (step_ff == STEP_WR_S2));
   assign dly_wk    = (step_ff == STEP_WR_S2);
   assign dly_waddr = DLY_AW'({band_ff, ch_ff, dly_wk});
   assign dly_wdata = dly_wk ? sat_sum(a2_ff) : sat_sum(a1_ff);

   bqeq_ram #(
      .WIDTH (STATE_WIDTH),
      .DEPTH (DLY_DEPTH)
   ) u_dly_ram (
      .clock   (clock),
      .wr_en   (dly_we),
      .wr_addr (dly_waddr),
      .wr_data (dly_wdata),
      .rd_en   (dly_re),
      .rd_addr (dly_raddr),
      .rd_data (dly_rd_data)
   );

   assign s_eff = dvld_ff ? dly_rd_data : '0;

   // ------------------------------------------------------------------------
   // Shared multiplier and accumulation
   // ------------------------------------------------------------------------
   // Odd steps multiply by the low half, even steps by the high half.
   assign mul_v = (step_ff >= STEP_MUL_Y) ? y_ff : x_ff;
   assign mop   = step_ff[0] ? {{(MOP_W - LO_W){1'b0}}, mul_v[LO_W-1:0]}
                             : {mul_v[STATE_WIDTH-1], mul_v[STATE_WIDTH-1:LO_W]};
   assign pp_in = coef_eff * mop;

   assign p_val = sat_prod(acc_ff);
   assign p_ext = SUM_W'(p_val);
   assign s_ext = SUM_W'(s_eff);

   // Output scaling by 32767 is done as (m << 15) - m.
   assign absx    = x_ff[STATE_WIDTH-1] ? -((STATE_WIDTH + 1)'(x_ff))
                                        : (STATE_WIDTH + 1)'(x_ff);
   assign scaled  = {mag_ff, {SAMPLE_FRAC{1'b0}}} - SCL_W'(mag_ff);
   assign mag_out = scaled[SCL_W-1:STATE_FRAC];

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      ya_in   = ya_ff;
      a1_in   = a1_ff;
      a2_in   = a2_ff;
      cuse_in = cuse_ff;
      cdef_in = cdef_ff;
      dvld_in = dvld_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;

      if (accept && (req_op == OP_FILTER)) begin
         x_in = STATE_WIDTH'(req_sample_in) <<< IN_SHIFT;
      end

      if (coef_re) begin
         cuse_in = coef_vld_ff[coef_raddr];
         cdef_in = (coef_k == CSEL_B0) ? COEFF_ONE : '0;
      end
      if (dly_re) begin
         dvld_in = dly_vld_ff[dly_raddr];
      end

      if (in_band) begin
         if ((step_ff >= STEP_FIRST_ACC) && (step_ff <= STEP_LAST_ADD)) begin
            if (!step_ff[0]) begin
               acc_in = PROD_W'(pp_ff);
            end else begin
               acc_in = acc_ff + (PROD_W'(pp_ff) <<< LO_W);
            end
         end

         unique case (step_ff)
            STEP_SUM_Y:  ya_in = p_ext + s_ext;
            STEP_SUM_A1: a1_in = p_ext + s_ext;
            STEP_SUM_A2: a2_in = p_ext;
            STEP_SUB_A1: a1_in = a1_ff - p_ext;
            STEP_SUB_A2: a2_in = a2_ff - p_ext;
            default: ;
         endcase

         if (step_ff == STEP_LOAD_Y) begin
            y_in = sat_sum(ya_ff);
         end
         if (step_ff == STEP_WR_S2) begin
            x_in = y_ff;
         end
      end

      if (state_ff == ST_FIN_MAG) begin
         neg_in = x_ff[STATE_WIDTH-1];
         mag_in = (absx > (STATE_WIDTH + 1)'(MAG_LIMIT)) ? MAG_LIMIT : MAG_W'(absx);
      end
      if (state_ff == ST_FIN_SCALE) begin
         res_in = neg_ff ? -signed'(mag_out) : signed'(mag_out);
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      pp_ff   <= pp_in;
      acc_ff  <= acc_in;
      ya_ff   <= ya_in;
      a1_ff   <= a1_in;
      a2_ff   <= a2_in;
      cuse_ff <= cuse_in;
      cdef_ff <= cdef_in;
      dvld_ff <= dvld_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      band_in        = band_ff;
      ch_in          = ch_ff;
      en_in          = en_ff;
      coef_vld_in    = coef_vld_ff;
      dly_vld_in     = dly_vld_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_channel_in = rsp_channel_ff;
      rsp_sample_in  = rsp_sample_ff;

      if (csr_wr_en) begin
         en_in = csr_wr_data & EN_MASK;
      end
      if (coef_we) begin
         coef_vld_in[coef_waddr] = 1'b1;
      end
      if (dly_we) begin
         dly_vld_in[dly_waddr] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_op == OP_FILTER) && ch_ok) begin
                  state_in = ST_BAND;
                  step_in  = STEP_FIRST;
                  band_in  = '0;
                  ch_in    = req_channel;
               end else if (req_op == OP_CLEAR) begin
                  dly_vld_in = '0;
               end
            end
         end
         ST_BAND: begin
            if (band_done) begin
               step_in = STEP_FIRST;
               if (band_ff == BAND_LAST) begin
                  state_in = ST_FIN_MAG;
               end else begin
                  band_in = band_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FIN_MAG: begin
            state_in = ST_FIN_SCALE;
         end
         ST_FIN_SCALE: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_load) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_channel_in = ch_ff;
               rsp_sample_in  = res_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_FIRST;
         band_ff      <= '0;
         ch_ff        <= 1'b0;
         en_ff        <= '0;
         coef_vld_ff  <= '0;
         dly_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         band_ff        <= band_in;
         ch_ff          <= ch_in;
         en_ff          <= en_in;
         coef_vld_ff    <= coef_vld_in;
         dly_vld_ff     <= dly_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_channel_ff <= rsp_channel_in;
         rsp_sample_ff  <= rsp_sample_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // A filter word keeps the input side stalled while it is processed.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == OP_FILTER) && ch_ok |=> req_stall)
      else $error("filter word accepted without stalling the input");

   // Only enabled bands get past their first step.
   assert property (@(posedge clock) disable iff (reset)
      in_band && (step_ff != STEP_FIRST) |-> band_en)
      else $error("disabled band is being processed");

   // The band counter never leaves the configured cascade.
   assert property (@(posedge clock) disable iff (reset)
      in_band |-> ({1'b0, band_ff} < (BAND_W + 1)'(NUM_BANDS)))
      else $error("band counter out of range");

   // A coefficient write never collides with a filter read.
   assert property (@(posedge clock) disable iff (reset)
      !(coef_we && coef_re))
      else $error("coefficient write during filtering");

   // A new result only appears after the send state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_SEND))
      else $error("result word appeared outside the send state");

endmodule
